// File: rtl/core/pbsd_pkg.sv
// Package for the PackBits strip decoder.
// Holds the decode phase and controller state types, the command and status structs
// and the fixed constants. It has no dependencies.
`timescale 1ns / 1ps

package pbsd_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // Register index, taken from the word address.
    localparam logic REG_MODE = 1'b0;

    // Header byte that encodes no run at all.
    localparam logic [7:0] HDR_NOP = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_REPEAT = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rep_step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic start_repeat;
        logic rep_final;
    } dp_status_t;

endpackage

// File: rtl/core/pbsd_if.sv
// Valid/ready channel interfaces for the PackBits strip decoder.
// One interface carries input requests and one carries decoded results; no dependencies.
`timescale 1ns / 1ps

interface pbsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       strip_last;

    modport source (output valid, output in_byte, output strip_last, input ready);
    modport sink (input valid, input in_byte, input strip_last, output ready);
endinterface

interface pbsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [1:0] byte_count;
    logic       run_last;
    logic       strip_end;
    logic       strip_error;

    modport source (output valid, output out_byte0, output out_byte1, output byte_count,
                    output run_last, output strip_end, output strip_error, input ready);
    modport sink (input valid, input out_byte0, input out_byte1, input byte_count,
                  input run_last, input strip_end, input strip_error, output ready);
endinterface

// File: rtl/core/pbsd_regs.sv
// APB configuration register file of the PackBits strip decoder.
// Holds the compression mode register; depends on pbsd_pkg.
`timescale 1ns / 1ps

module pbsd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbsd_pkg::ADDR_W-1:0] paddr,
    input  logic [pbsd_pkg::DATA_W-1:0] pwdata,
    output logic [pbsd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic                        compression_mode
);
    import pbsd_pkg::*;

    logic mode_reg;
    logic mode_next;
    logic wr_en;
    logic sel_mode;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[2] == REG_MODE);
    assign wr_en    = psel && penable && pwrite && pready && sel_mode;

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en)
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign prdata           = sel_mode ? {{(DATA_W-1){1'b0}}, mode_reg} : '0;
    assign compression_mode = mode_reg;

endmodule

// File: rtl/core/pbsd_ctrl.sv
// Controller of the PackBits strip decoder.
// Sequences input acceptance and repeat-run emission; depends on pbsd_pkg.
`timescale 1ns / 1ps

module pbsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pbsd_pkg::dp_status_t status,
    output pbsd_pkg::dp_cmd_t    cmd
);
    import pbsd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rep_step = 1'b0;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                in_ready   = status.out_free;
                cmd.accept = in_valid && status.out_free;
                if (cmd.accept && status.start_repeat)
                begin
                    state_next = ST_REPEAT;
                end
            end
            ST_REPEAT:
            begin
                cmd.rep_step = status.out_free;
                if (cmd.rep_step && status.rep_final)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

endmodule

// File: rtl/core/pbsd_datapath.sv
// Datapath of the PackBits strip decoder.
// Holds the decode state, the repeat counter and the output register; depends on pbsd_pkg.
`timescale 1ns / 1ps

module pbsd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 compression_mode,
    input  logic [7:0]           in_byte,
    input  logic                 strip_last,
    input  pbsd_pkg::dp_cmd_t    cmd,
    output pbsd_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte0,
    output logic [7:0]           out_byte1,
    output logic [1:0]           byte_count,
    output logic                 run_last,
    output logic                 strip_end,
    output logic                 strip_error
);
    import pbsd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;

    logic [7:0] rep_left_reg;
    logic [7:0] rep_byte_reg;
    logic       rep_last_reg;

    logic       valid_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [1:0] cnt_reg;
    logic       rl_reg;
    logic       se_reg;
    logic       err_reg;

    logic       res_load;
    logic [7:0] res_b0;
    logic [1:0] res_cnt;
    logic       res_se;
    logic       res_err;
    logic [7:0] lit_dec;
    logic [8:0] rep_count;
    phase_t     hdr_phase;

    logic       rep_pair;
    logic [1:0] rep_cnt;

    assign rep_count = 9'd257 - {1'b0, in_byte};
    assign lit_dec   = (left_reg != 8'd0) ? (left_reg - 8'd1) : 8'd0;

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        res_load   = 1'b0;
        res_b0     = 8'd0;
        res_cnt    = 2'd0;
        res_se     = strip_last;
        res_err    = 1'b0;
        hdr_phase  = PH_HEADER;
        if (!compression_mode)
        begin
            res_load = 1'b1;
            res_b0   = in_byte;
            res_cnt  = 2'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_LITERAL:
                begin
                    res_load   = 1'b1;
                    res_b0     = in_byte;
                    res_cnt    = 2'd1;
                    left_next  = lit_dec;
                    phase_next = (lit_dec == 8'd0) ? PH_HEADER : PH_LITERAL;
                    res_err    = strip_last && (lit_dec != 8'd0);
                end
                PH_REPEAT:
                begin
                    res_load   = (left_reg == 8'd0);
                    phase_next = PH_HEADER;
                    left_next  = 8'd0;
                end
                default:
                begin
                    if (!in_byte[7])
                    begin
                        hdr_phase = PH_LITERAL;
                        left_next = in_byte + 8'd1;
                    end
                    else if (in_byte != HDR_NOP)
                    begin
                        hdr_phase = PH_REPEAT;
                        left_next = rep_count[7:0];
                    end
                    else
                    begin
                        hdr_phase = PH_HEADER;
                        left_next = 8'd0;
                    end
                    phase_next = hdr_phase;
                    res_load   = strip_last;
                    res_err    = (hdr_phase != PH_HEADER);
                end
            endcase
        end
        if (strip_last)
        begin
            phase_next = PH_HEADER;
            left_next  = 8'd0;
        end
    end

    assign rep_pair = (rep_left_reg >= 8'd2);
    assign rep_cnt  = rep_pair ? 2'd2 : 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
            end
            if ((cmd.accept && res_load) || cmd.rep_step)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.start_repeat)
        begin
            rep_left_reg <= left_reg;
            rep_byte_reg <= in_byte;
            rep_last_reg <= strip_last;
        end
        else if (cmd.rep_step)
        begin
            rep_left_reg <= rep_left_reg - {6'd0, rep_cnt};
        end

        if (cmd.accept && res_load)
        begin
            b0_reg  <= res_b0;
            b1_reg  <= 8'd0;
            cnt_reg <= res_cnt;
            rl_reg  <= 1'b1;
            se_reg  <= res_se;
            err_reg <= res_err;
        end
        else if (cmd.rep_step)
        begin
            b0_reg  <= rep_byte_reg;
            b1_reg  <= rep_pair ? rep_byte_reg : 8'd0;
            cnt_reg <= rep_cnt;
            rl_reg  <= status.rep_final;
            se_reg  <= status.rep_final && rep_last_reg;
            err_reg <= 1'b0;
        end
    end

    assign status.out_free     = !valid_reg || out_ready;
    assign status.start_repeat = compression_mode && (phase_reg == PH_REPEAT)
                                 && (left_reg != 8'd0);
    assign status.rep_final    = (rep_left_reg <= 8'd2);

    assign out_valid   = valid_reg;
    assign out_byte0   = b0_reg;
    assign out_byte1   = b1_reg;
    assign byte_count  = cnt_reg;
    assign run_last    = rl_reg;
    assign strip_end   = se_reg;
    assign strip_error = err_reg;

endmodule

// File: rtl/core/packbits_strip_decoder.sv
// Top level of the PackBits strip decoder.
// Joins the APB registers, the controller and the datapath; depends on pbsd_pkg,
// pbsd_if, pbsd_regs, pbsd_ctrl and pbsd_datapath.
//
// Usage: compressed strip bytes enter on din, one request per byte, with strip_last
// set on the strip's final byte. Decoded results leave on dout with up to two bytes
// each. The APB register compression_mode at address 0 selects pass-through (0) or
// PackBits decoding (1); write it only while the block is idle.
// A pass-through, literal or strip-closing header result appears in the cycle
// after its request; the first pair of a repeat run is loaded from the repeat
// registers once the controller is in ST_REPEAT. Throughput: one request per
// cycle for headers, literal and pass-through bytes while dout is not stalled.
// After a repeat run's byte is taken, din is held while its pairs are emitted.
// A header byte that does not end a strip produces no result.
// Reset clears the mode to pass-through and the decoder to expect a header.
// When dout stalls, the output register holds its result and din stops taking
// requests until the register is free again; nothing is lost or repeated.
// A result with strip_error set marks the strip's partial output as bad.
`timescale 1ns / 1ps

module packbits_strip_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbsd_pkg::ADDR_W-1:0] paddr,
    input  logic [pbsd_pkg::DATA_W-1:0] pwdata,
    output logic [pbsd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    pbsd_in_if.sink                     din,
    pbsd_out_if.source                  dout
);
    import pbsd_pkg::*;

    logic       compression_mode;
    dp_cmd_t    cmd;
    dp_status_t status;

    pbsd_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .compression_mode (compression_mode)
    );

    pbsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbsd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .compression_mode (compression_mode),
        .in_byte          (din.in_byte),
        .strip_last       (din.strip_last),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (dout.valid),
        .out_ready        (dout.ready),
        .out_byte0        (dout.out_byte0),
        .out_byte1        (dout.out_byte1),
        .byte_count       (dout.byte_count),
        .run_last         (dout.run_last),
        .strip_end        (dout.strip_end),
        .strip_error      (dout.strip_error)
    );

endmodule
